### rtl/bayer_bilinear_demosaic_defines.svh
// assertion macros for the bayer demosaic block
// expects clk and arst_n in the scope of each use
`ifndef BAYER_BILINEAR_DEMOSAIC_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_DEFINES_SVH

// property must hold at every clock edge outside reset
`define BBD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition must never be seen outside reset
`define BBD_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

### rtl/bbd_pkg.sv
// shared types, register indexes and colour layout for the bayer demosaic block
// no dependencies
package bbd_pkg;

	typedef enum logic [1:0] {
		COL_RED   = 2'd0,
		COL_GREEN = 2'd1,
		COL_BLUE  = 2'd2
	} colour_t;

	localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_BAYER_PATTERN = 2'd2;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// colour per pattern, indexed by {row odd, column odd}
	localparam logic [1:0] COLOUR_OF [4][4] = '{
		'{2'd0, 2'd1, 2'd1, 2'd2},
		'{2'd2, 2'd1, 2'd1, 2'd0},
		'{2'd1, 2'd0, 2'd2, 2'd1},
		'{2'd1, 2'd2, 2'd0, 2'd1}
	};

	// centre parity and which neighbour rows and columns lie inside the frame
	typedef struct packed {
		logic y_odd;
		logic x_odd;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
	} geo_t;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        row_end;
		logic        frame_end;
	} res_t;

	function automatic colour_t site_colour(logic [1:0] pat, logic y_odd, logic x_odd);
		return colour_t'(COLOUR_OF[pat][{y_odd, x_odd}]);
	endfunction

endpackage

### rtl/bayer_bilinear_demosaic.sv
// bilinear bayer demosaic: one raw pixel accepted per cycle while in_ready, results via stages 1 and 2 into the queue
// an item that ends any row but the first gives two results; an 8-entry result queue absorbs them
// one request per cycle while in_ready is high: line memory reads at request and writes back in the next cycle
// input stalls while more than 6 results are queued or in flight
// output pixel (r-1, c-1) follows raw pixel (r, c); width drain items flush the last row
// reset (arst_n low) clears counters, pipeline, window and queue; line memory keeps contents
`include "bayer_bilinear_demosaic_defines.svh"
module bayer_bilinear_demosaic import bbd_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int PIXEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue,
	output logic        row_end,
	output logic        frame_end
);
	localparam int AW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int PW  = PIXEL_BITS;
	localparam int SW  = PW + 2;
	localparam int FD  = 8;
	localparam int FAW = $clog2(FD);
	localparam int FCW = FAW + 1;

	// configuration registers
	logic [12:0] fw_q;
	logic [15:0] fh_q;
	logic [1:0]  pat_q;
	logic        cfg_hit;

	// frame counters
	logic [AW-1:0] col_q;
	logic [15:0]   row_q;
	logic [AW-1:0] drain_q;

	// request decode
	logic          in_acc;
	logic [WW-1:0] ew;
	logic [15:0]   eh;
	logic [WW-1:0] c_ext;
	logic [WW-1:0] d_ext;
	logic [WW-1:0] pos;
	logic [WW-1:0] pos_inc;
	logic          is_drain;
	logic          act;
	logic          last;
	logic          emit_a;
	logic          emit_b;
	geo_t          geo_a;
	geo_t          geo_b;
	logic [AW-1:0] rd_addr;

	// stage 1: line memory data back, window update, write back
	logic              v_s1;
	logic              drain_s1;
	logic              emit_a_s1;
	logic              emit_b_s1;
	geo_t              geo_a_s1;
	geo_t              geo_b_s1;
	logic [PW-1:0]     px_s1;
	logic [AW-1:0]     addr_s1;
	logic [2*PW-1:0]   rd_s1;
	logic              fwd_s1;
	logic [2*PW-1:0]   fwd_word_s1;
	logic [2*PW-1:0]   mem_word;
	logic [2*PW-1:0]   wr_word;
	logic              wr_en;
	logic [PW-1:0]     older;
	logic [PW-1:0]     newer;
	logic [8:0][PW-1:0] win_q;
	logic [8:0][PW-1:0] win_a;
	logic [8:0][PW-1:0] win_b;
	logic [2:0][SW-1:0] sum_a;
	logic [2:0][SW-1:0] sum_b;
	logic [2:0][2:0]    cnt_a;
	logic [2:0][2:0]    cnt_b;
	colour_t            own_a;
	colour_t            own_b;

	// stage 2: divide and push into the result queue
	logic               va_s2;
	logic               vb_s2;
	logic               fe_s2;
	logic [2:0][SW-1:0] sum_a_s2;
	logic [2:0][SW-1:0] sum_b_s2;
	logic [2:0][2:0]    cnt_a_s2;
	logic [2:0][2:0]    cnt_b_s2;
	colour_t            own_a_s2;
	colour_t            own_b_s2;
	logic [PW-1:0]      cen_a_s2;
	logic [PW-1:0]      cen_b_s2;
	res_t               res_a;
	res_t               res_b;

	// result queue
	res_t           fifo_q [FD];
	logic [FAW-1:0] wp_q;
	logic [FAW-1:0] rp_q;
	logic [FCW-1:0] cnt_q;
	logic [1:0]     n_push;
	logic [1:0]     n_s1;
	logic [1:0]     n_s2;
	logic [FCW:0]   pend;
	logic           pop;

	logic [2*PW-1:0] line_mem [MAX_WIDTH];

	assign in_acc  = in_valid & in_ready;
	assign cfg_hit = cfg_write && (cfg_index == REG_FRAME_WIDTH
		|| cfg_index == REG_FRAME_HEIGHT || cfg_index == REG_BAYER_PATTERN);

	// effective frame size, width clamped to the line memory, width and height held at 2 or more
	always_comb begin
		if (32'(fw_q) > MAX_WIDTH) begin
			ew = WW'(MAX_WIDTH);
		end else if (fw_q < 13'd2) begin
			ew = WW'(2);
		end else begin
			ew = WW'(fw_q);
		end
	end
	assign eh = (fh_q < 16'd2) ? 16'd2 : fh_q;

	// column position of this request, raw column or drain step
	assign c_ext    = WW'(col_q);
	assign d_ext    = (WW'(drain_q) >= ew) ? (ew - WW'(1)) : WW'(drain_q);
	assign is_drain = (cmd == CMD_DRAIN);
	assign pos      = is_drain ? d_ext : c_ext;
	assign pos_inc  = pos + WW'(1);
	assign last     = (pos_inc >= ew);

	// raw pixels past the last row and drains before it are dropped
	assign act = is_drain ? (row_q >= eh) : ((row_q < eh) && (c_ext < ew));

	// centre row is row_q - 1 both for raw pixels and for drain steps
	assign emit_a = act && (row_q != 16'd0) && (pos != WW'(0));
	assign emit_b = act && (row_q != 16'd0) && last;

	always_comb begin
		geo_a.y_odd    = ~row_q[0];
		geo_a.top_ok   = (row_q >= 16'd2);
		geo_a.bot_ok   = (row_q < eh);
		geo_a.x_odd    = ~pos[0];
		geo_a.left_ok  = (pos >= WW'(2));
		geo_a.right_ok = (pos < ew);
		geo_b          = geo_a;
		geo_b.x_odd    = pos[0];
		geo_b.left_ok  = (pos != WW'(0));
		geo_b.right_ok = (pos_inc < ew);
	end

	assign rd_addr = AW'(pos);

	// configuration and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= 13'd4096;
			fh_q    <= 16'd2048;
			pat_q   <= 2'd0;
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_FRAME_WIDTH:   fw_q  <= cfg_data[12:0];
				REG_FRAME_HEIGHT:  fh_q  <= cfg_data;
				REG_BAYER_PATTERN: pat_q <= cfg_data[1:0];
				default:           ;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (in_acc && act) begin
			if (is_drain) begin
				if (last) begin
					// end of frame, start over
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= AW'(pos_inc);
				end
			end else if (last) begin
				col_q <= '0;
				row_q <= row_q + 16'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// line memory: {older row, newer row} per column, read at request, written in stage 1
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1 <= line_mem[rd_addr];
		end
		if (wr_en) begin
			line_mem[addr_s1] <= wr_word;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			emit_a_s1 <= 1'b0;
			emit_b_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			v_s1      <= in_acc && act;
			emit_a_s1 <= in_acc && emit_a;
			emit_b_s1 <= in_acc && emit_b;
			// same column read while the item ahead writes it back
			fwd_s1    <= in_acc && wr_en && (addr_s1 == rd_addr);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			drain_s1    <= is_drain;
			px_s1       <= pixel[PW-1:0];
			addr_s1     <= rd_addr;
			geo_a_s1    <= geo_a;
			geo_b_s1    <= geo_b;
			fwd_word_s1 <= wr_word;
		end
	end

	assign mem_word = fwd_s1 ? fwd_word_s1 : rd_s1;
	assign older    = mem_word[2*PW-1:PW];
	assign newer    = mem_word[PW-1:0];
	assign wr_en    = v_s1 && !drain_s1;
	assign wr_word  = {newer, px_s1};

	// window after the request's shift, and after the extra blank shift at row end
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_a[k*3+0] = win_q[k*3+1];
			win_a[k*3+1] = win_q[k*3+2];
			win_b[k*3+0] = win_a[k*3+1];
			win_b[k*3+1] = win_a[k*3+2];
			win_b[k*3+2] = '0;
		end
		win_a[2] = older;
		win_a[5] = newer;
		win_a[8] = drain_s1 ? '0 : px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			win_q <= emit_b_s1 ? win_b : win_a;
		end
	end

	bbd_sum #(.PW(PW)) u_sum_a (
		.pattern (pat_q),
		.geo     (geo_a_s1),
		.win     (win_a),
		.sum     (sum_a),
		.cnt     (cnt_a),
		.own     (own_a)
	);

	bbd_sum #(.PW(PW)) u_sum_b (
		.pattern (pat_q),
		.geo     (geo_b_s1),
		.win     (win_b),
		.sum     (sum_b),
		.cnt     (cnt_b),
		.own     (own_b)
	);

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s2 <= 1'b0;
			vb_s2 <= 1'b0;
		end else begin
			va_s2 <= emit_a_s1;
			vb_s2 <= emit_b_s1;
		end
	end

	always_ff @(posedge clk) begin
		fe_s2    <= drain_s1;
		sum_a_s2 <= sum_a;
		sum_b_s2 <= sum_b;
		cnt_a_s2 <= cnt_a;
		cnt_b_s2 <= cnt_b;
		own_a_s2 <= own_a;
		own_b_s2 <= own_b;
		cen_a_s2 <= win_a[4];
		cen_b_s2 <= win_b[4];
	end

	bbd_avg #(.PW(PW)) u_avg_a (
		.sum    (sum_a_s2),
		.cnt    (cnt_a_s2),
		.own    (own_a_s2),
		.centre (cen_a_s2),
		.red    (res_a.red),
		.green  (res_a.green),
		.blue   (res_a.blue)
	);

	bbd_avg #(.PW(PW)) u_avg_b (
		.sum    (sum_b_s2),
		.cnt    (cnt_b_s2),
		.own    (own_b_s2),
		.centre (cen_b_s2),
		.red    (res_b.red),
		.green  (res_b.green),
		.blue   (res_b.blue)
	);

	assign res_a.row_end   = 1'b0;
	assign res_a.frame_end = 1'b0;
	assign res_b.row_end   = 1'b1;
	assign res_b.frame_end = fe_s2;

	// result queue, up to two pushes a cycle, A before B
	assign n_push = {1'b0, va_s2} + {1'b0, vb_s2};
	assign n_s1   = {1'b0, emit_a_s1} + {1'b0, emit_b_s1};
	assign n_s2   = n_push;
	assign pop    = out_valid && out_ready;

	// results already promised to the queue bound the next request
	assign pend     = (FCW+1)'(cnt_q) + (FCW+1)'(n_s1) + (FCW+1)'(n_s2);
	assign in_ready = (pend <= (FCW+1)'(FD - 2));

	always_ff @(posedge clk) begin
		if (va_s2) begin
			fifo_q[wp_q] <= res_a;
		end else if (vb_s2) begin
			fifo_q[wp_q] <= res_b;
		end
		if (va_s2 && vb_s2) begin
			fifo_q[wp_q + FAW'(1)] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FAW'(n_push);
			rp_q  <= rp_q + FAW'(pop);
			cnt_q <= cnt_q + FCW'(n_push) - FCW'(pop);
		end
	end

	assign out_valid = (cnt_q != '0);
	assign red       = fifo_q[rp_q].red;
	assign green     = fifo_q[rp_q].green;
	assign blue      = fifo_q[rp_q].blue;
	assign row_end   = fifo_q[rp_q].row_end;
	assign frame_end = fifo_q[rp_q].frame_end;

	`BBD_ASSERT(a_queue_bound, cnt_q <= FCW'(FD), "result queue overflow")
	`BBD_ASSERT(a_pending_bound, pend <= (FCW+1)'(FD), "more results promised than queue room")
	`BBD_ASSERT(a_row_end_pair, emit_b_s1 |-> emit_a_s1, "row end result without the one before it")
	`BBD_NEVER(a_frame_end_row, out_valid && frame_end && !row_end, "frame end off a row end")

endmodule

### rtl/bbd_sum.sv
// per colour neighbour sums and counts over one 3x3 window
// depends on bbd_pkg
module bbd_sum import bbd_pkg::*; #(
	parameter int PW = 16
) (
	input  logic [1:0]               pattern,
	input  geo_t                     geo,
	input  logic [8:0][PW-1:0]       win,
	output logic [2:0][PW+1:0]       sum,
	output logic [2:0][2:0]          cnt,
	output colour_t                  own
);
	localparam int SW = PW + 2;

	always_comb begin
		logic    in_frame;
		colour_t col;
		own = site_colour(pattern, geo.y_odd, geo.x_odd);
		sum = '0;
		cnt = '0;
		for (int dy = 0; dy < 3; dy++) begin
			for (int dx = 0; dx < 3; dx++) begin
				in_frame = !(dy == 1 && dx == 1)
					&& (dy != 0 || geo.top_ok) && (dy != 2 || geo.bot_ok)
					&& (dx != 0 || geo.left_ok) && (dx != 2 || geo.right_ok);
				col = site_colour(pattern, geo.y_odd ^ (dy != 1), geo.x_odd ^ (dx != 1));
				if (in_frame) begin
					sum[col] = sum[col] + SW'(win[dy*3+dx]);
					cnt[col] = cnt[col] + 3'd1;
				end
			end
		end
	end

endmodule

### rtl/bbd_avg.sv
// truncated mean per colour from neighbour sums, own colour passed through
// depends on bbd_pkg
module bbd_avg import bbd_pkg::*; #(
	parameter int PW = 16
) (
	input  logic [2:0][PW+1:0] sum,
	input  logic [2:0][2:0]    cnt,
	input  colour_t            own,
	input  logic [PW-1:0]      centre,
	output logic [15:0]        red,
	output logic [15:0]        green,
	output logic [15:0]        blue
);
	localparam int SW  = PW + 2;
	localparam int MSH = SW + 1;
	// reciprocal of three, exact for every sum below 2**SW
	localparam longint unsigned M3L = ((64'd1 << MSH) + 64'd2) / 64'd3;

	logic [SW-1:0]      m3;
	logic [SW-1:0]      sel;
	logic [2*SW-1:0]    prod;
	logic [PW-1:0]      q3;
	logic [2:0][PW-1:0] val;

	assign m3 = SW'(M3L);

	// at most one colour has three neighbours, so one multiplier serves
	always_comb begin
		sel = '0;
		for (int k = 0; k < 3; k++) begin
			if (cnt[k] == 3'd3) begin
				sel = sum[k];
			end
		end
	end

	assign prod = (2*SW)'(sel) * (2*SW)'(m3);
	assign q3   = PW'(prod >> MSH);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (own == colour_t'(k)) begin
				val[k] = centre;
			end else begin
				case (cnt[k])
					3'd1:    val[k] = PW'(sum[k]);
					3'd2:    val[k] = PW'(sum[k] >> 1);
					3'd3:    val[k] = q3;
					3'd4:    val[k] = PW'(sum[k] >> 2);
					default: val[k] = '0;
				endcase
			end
		end
	end

	assign red   = 16'(val[COL_RED]);
	assign green = 16'(val[COL_GREEN]);
	assign blue  = 16'(val[COL_BLUE]);

endmodule
